### sv/adaptive_threshold_spike_generator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive threshold spike generator
// Shared concurrent property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_THRESHOLD_SPIKE_GENERATOR_TOP_DEFINES_SVH
`define ADAPTIVE_THRESHOLD_SPIKE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ATSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atsg port check failed");

// Next-cycle implication, disabled while reset is asserted
`define ATSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atsg port check failed");

`endif

### sv/atsg_pkg.sv
// ---------------------------------------------------------------------------
// atsg_pkg
// Shared widths, register indexes and control types of the spike generator.
// ---------------------------------------------------------------------------
`default_nettype none

package atsg_pkg;

  localparam int ATSG_NUM_COMPONENTS = 2;
  localparam int ATSG_MAX_UPSAMPLE   = 16;

  localparam int VAL_W    = 32;
  localparam int DECAY_W  = 16;
  localparam int REFR_W   = 16;
  localparam int UPS_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SLOTS  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FAST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SLOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_FAST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_SLOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_BINS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_FACTOR = 3'd5;

  // Reset values of the registers
  localparam logic [DECAY_W-1:0] DECAY_FAST_RST = 16'd60000;
  localparam logic [DECAY_W-1:0] DECAY_SLOW_RST = 16'd65000;
  localparam logic [UPS_W-1:0]   UPSAMPLE_RST   = 5'd1;

  // Current register contents
  typedef struct packed {
    logic [CFG_SLOTS-1:0][DECAY_W-1:0] decay;
    logic [CFG_SLOTS-1:0][VAL_W-1:0]   jump;
    logic [REFR_W-1:0]                 refractory_bins;
    logic [UPS_W-1:0]                  upsample_factor;
  } atsg_cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the drive voltage of an accepted request
    logic mul;       // form the decay products of all components
    logic commit;    // finish a bin: update state, load the result register
    logic last;      // the bin being committed closes the request
  } atsg_cmd_t;

endpackage

`default_nettype wire

### sv/adaptive_threshold_spike_generator_top.sv
// ---------------------------------------------------------------------------
// adaptive_threshold_spike_generator_top
// Adaptive threshold neuron: one voltage request yields one result per fine
// time bin, with two decaying, saturating threshold components.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_drive_voltage
//   out      output     out_valid/out_stall out_spike, out_threshold_sum,
//                                           out_last_bin
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each bin has a multiply step, in which the decay multipliers are registered,
// then an update step: the round, sum, compare and jump update close the bin.
// A request is captured when idle, then runs as many bins as the clamped upsample factor.
// Output stall holds the update step; a new request is taken as soon as the
// last bin enters the result register. Reset is synchronous and clears the
// components to zero and the refractory count to one.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_threshold_spike_generator_top
  import atsg_pkg::*;
#(
  parameter int NUM_COMPONENTS = ATSG_NUM_COMPONENTS,
  parameter int MAX_UPSAMPLE   = ATSG_MAX_UPSAMPLE
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [VAL_W-1:0] in_drive_voltage,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_spike,
  output logic signed [VAL_W-1:0]      out_threshold_sum,
  output logic                         out_last_bin,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  atsg_cfg_t cfg;
  atsg_cmd_t cmd;

  atsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  atsg_ctrl #(
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .upsample_factor (cfg.upsample_factor),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cmd             (cmd)
  );

  atsg_datapath #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .in_drive_voltage  (in_drive_voltage),
    .out_spike         (out_spike),
    .out_threshold_sum (out_threshold_sum),
    .out_last_bin      (out_last_bin)
  );

endmodule

`default_nettype wire

### sv/atsg_cfg_regs.sv
// ---------------------------------------------------------------------------
// atsg_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module atsg_cfg_regs
  import atsg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output atsg_cfg_t                  cfg
);

  atsg_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay[0]         <= DECAY_FAST_RST;
      cfg_r.decay[1]         <= DECAY_SLOW_RST;
      cfg_r.jump[0]          <= '0;
      cfg_r.jump[1]          <= '0;
      cfg_r.refractory_bins  <= '0;
      cfg_r.upsample_factor  <= UPSAMPLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DECAY_FAST:      cfg_r.decay[0]        <= cfg_data[DECAY_W-1:0];
        REG_DECAY_SLOW:      cfg_r.decay[1]        <= cfg_data[DECAY_W-1:0];
        REG_JUMP_FAST:       cfg_r.jump[0]         <= cfg_data[VAL_W-1:0];
        REG_JUMP_SLOW:       cfg_r.jump[1]         <= cfg_data[VAL_W-1:0];
        REG_REFRACTORY_BINS: cfg_r.refractory_bins <= cfg_data[REFR_W-1:0];
        REG_UPSAMPLE_FACTOR: cfg_r.upsample_factor <= cfg_data[UPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/atsg_datapath.sv
// ---------------------------------------------------------------------------
// atsg_datapath
// Threshold components, decay multipliers, compare, refractory counter and
// the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module atsg_datapath
  import atsg_pkg::*;
#(
  parameter int NUM_COMPONENTS = ATSG_NUM_COMPONENTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire atsg_cfg_t               cfg,
  input  wire atsg_cmd_t               cmd,
  input  wire logic signed [VAL_W-1:0] in_drive_voltage,
  output logic                         out_spike,
  output logic signed [VAL_W-1:0]      out_threshold_sum,
  output logic                         out_last_bin
);

  localparam int PROD_W = VAL_W + DECAY_W + 1;
  localparam int SUM_W  = VAL_W + 2;

  logic signed [VAL_W-1:0]  volt_r;
  logic signed [PROD_W-1:0] prod_r  [NUM_COMPONENTS];
  logic signed [PROD_W-1:0] rnd     [NUM_COMPONENTS];
  logic signed [VAL_W-1:0]  dec     [NUM_COMPONENTS];
  logic signed [VAL_W-1:0]  part_r  [NUM_COMPONENTS];
  logic signed [VAL_W-1:0]  part_nxt[NUM_COMPONENTS];
  logic [REFR_W-1:0]        refr_r;
  logic [REFR_W-1:0]        refr_nxt;
  logic signed [SUM_W-1:0]  total;
  logic signed [VAL_W-1:0]  thr;
  logic                     fire;

  function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      sat_wide = hi[VAL_W-1:0];
    end else if (x < lo) begin
      sat_wide = lo[VAL_W-1:0];
    end else begin
      sat_wide = x[VAL_W-1:0];
    end
  endfunction

  // Hold the drive voltage for all bins of a request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      volt_r <= in_drive_voltage;
    end
  end

  // Multiply each component by its decay factor
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        prod_r[j] <= PROD_W'(part_r[j]) * PROD_W'($signed({1'b0, cfg.decay[j]}));
      end
    end
  end

  // Round the products, sum, compare, apply the jump on a spike and step the refractory count
  always_comb begin
    total = '0;
    for (int j = 0; j < NUM_COMPONENTS; j++) begin
      rnd[j] = prod_r[j] + PROD_W'(32768);
      dec[j] = rnd[j][VAL_W+DECAY_W-1:DECAY_W];
      total  = total + SUM_W'(dec[j]);
    end
    thr  = sat_wide(total);
    fire = (refr_r == '0) && (volt_r > thr);
    for (int j = 0; j < NUM_COMPONENTS; j++) begin
      if (fire) begin
        part_nxt[j] = sat_wide(SUM_W'(dec[j]) + SUM_W'(signed'(cfg.jump[j])));
      end else begin
        part_nxt[j] = dec[j];
      end
    end
    if (refr_r != '0) begin
      refr_nxt = refr_r - REFR_W'(1);
    end else if (fire) begin
      refr_nxt = cfg.refractory_bins;
    end else begin
      refr_nxt = refr_r;
    end
  end

  // Advance neuron state at the end of each bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        part_r[j] <= '0;
      end
      refr_r <= REFR_W'(1);
    end else if (cmd.commit) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        part_r[j] <= part_nxt[j];
      end
      refr_r <= refr_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_spike         <= fire;
      out_threshold_sum <= thr;
      out_last_bin      <= cmd.last;
    end
  end

endmodule

`default_nettype wire

### sv/atsg_ctrl.sv
// ---------------------------------------------------------------------------
// atsg_ctrl
// Bin sequencer: accepts a request, runs multiply and update steps per bin,
// and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module atsg_ctrl
  import atsg_pkg::*;
#(
  parameter int MAX_UPSAMPLE = ATSG_MAX_UPSAMPLE
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [UPS_W-1:0] upsample_factor,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output atsg_cmd_t             cmd
);

  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);
  localparam int EW    = (CNT_W > UPS_W) ? CNT_W : UPS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [EW-1:0]    ups_ext;
  logic [EW-1:0]    bins_eff;

  // Clamp the bin count to one through MAX_UPSAMPLE
  always_comb begin
    ups_ext = EW'(upsample_factor);
    if (ups_ext == '0) begin
      bins_eff = EW'(1);
    end else if (ups_ext > EW'(MAX_UPSAMPLE)) begin
      bins_eff = EW'(MAX_UPSAMPLE);
    end else begin
      bins_eff = ups_ext;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the bins of one request
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          rem_nxt     = CNT_W'(bins_eff);
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          cmd.last      = (rem_r == CNT_W'(1));
          out_valid_nxt = 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt   = rem_r - CNT_W'(1);
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, bin count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/atsg_checker.sv
// ---------------------------------------------------------------------------
// atsg_checker
// Port-level checks of the spike generator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "adaptive_threshold_spike_generator_top_defines.svh"

module atsg_checker
  import atsg_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic signed [VAL_W-1:0] in_drive_voltage,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    out_spike,
  input wire logic signed [VAL_W-1:0] out_threshold_sum,
  input wire logic                    out_last_bin,
  input wire logic                    cfg_valid,
  input wire logic                    cfg_ready,
  input wire logic [CFG_IDX_W-1:0]    cfg_index,
  input wire logic [CFG_DATA_W-1:0]   cfg_data
);

  // A stalled result keeps its valid and payload
  `ATSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_spike) && $stable(out_threshold_sum) && $stable(out_last_bin))

  // An accepted request occupies the block for at least the multiply and update
  `ATSG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall ##1 in_stall)

  // While a non-final bin waits, the request is not finished
  `ATSG_ASSERT_NEXT(a_busy_mid_request, out_valid && out_stall && !out_last_bin, in_stall)

  // A stalled request keeps its valid and voltage
  `ATSG_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_drive_voltage))

  // A waiting register write keeps its index and data
  `ATSG_ASSERT_NEXT(a_cfg_hold, cfg_valid && !cfg_ready, cfg_valid && $stable(cfg_index) && $stable(cfg_data))

endmodule

bind adaptive_threshold_spike_generator_top atsg_checker u_atsg_checker (.*);

`default_nettype wire

### dv/atsg_bin_checker.sv
// ---------------------------------------------------------------------------
// atsg_bin_checker
// Watches the request, result and register channels of the spike generator,
// keeps its own copy of the neuron state and register file, predicts every
// fine bin of each accepted voltage request and compares the results field
// by field, oldest first.
// ---------------------------------------------------------------------------
module atsg_bin_checker
  import atsg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic signed [VAL_W-1:0] in_drive_voltage,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic                    out_spike,
  input  wire logic signed [VAL_W-1:0] out_threshold_sum,
  input  wire logic                    out_last_bin,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output int                           mismatch_count,
  output int                           bins_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;
  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

  typedef struct packed {
    logic             spike;
    logic [VAL_W-1:0] thr;
    logic             last;
  } bin_result_t;

  // Mirror of the register file
  logic [DECAY_W-1:0]      decay_q [ATSG_NUM_COMPONENTS];
  logic signed [VAL_W-1:0] jump_q  [ATSG_NUM_COMPONENTS];
  logic [REFR_W-1:0]       refr_bins_q;
  logic [UPS_W-1:0]        upsample_q;

  // Mirror of the neuron state
  logic signed [VAL_W-1:0] part_q  [ATSG_NUM_COMPONENTS];
  logic [REFR_W-1:0]       refr_count_q;

  bin_result_t expected_bins[$];
  int          bins_seen;

  initial begin
    mismatch_count = 0;
    bins_pending   = 0;
    bins_seen      = 0;
  end

  function automatic logic signed [VAL_W-1:0] clip32(input logic signed [33:0] x);
    if (x > SUM_MAX) return SUM_MAX[VAL_W-1:0];
    if (x < SUM_MIN) return SUM_MIN[VAL_W-1:0];
    return x[VAL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: bin %0d mismatch on %s: expected %h, got %h",
               $time, bins_seen, what, want, got);
    mismatch_count++;
  endtask

  // Load the power-up register and state values
  task automatic clear_model();
    decay_q[0]   = DECAY_FAST_RST;
    decay_q[1]   = DECAY_SLOW_RST;
    jump_q[0]    = '0;
    jump_q[1]    = '0;
    refr_bins_q  = '0;
    upsample_q   = UPSAMPLE_RST;
    part_q[0]    = '0;
    part_q[1]    = '0;
    refr_count_q = REFR_W'(1);
    expected_bins.delete();
  endtask

  // Apply a register write; unknown indexes are dropped
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DECAY_FAST:      decay_q[0]  = data[DECAY_W-1:0];
      REG_DECAY_SLOW:      decay_q[1]  = data[DECAY_W-1:0];
      REG_JUMP_FAST:       jump_q[0]   = data[VAL_W-1:0];
      REG_JUMP_SLOW:       jump_q[1]   = data[VAL_W-1:0];
      REG_REFRACTORY_BINS: refr_bins_q = data[REFR_W-1:0];
      REG_UPSAMPLE_FACTOR: upsample_q  = data[UPS_W-1:0];
      default: ;
    endcase
  endtask

  // Run all fine bins of one voltage request and queue their results
  task automatic predict_bins(input logic signed [VAL_W-1:0] volt);
    int                      nbins;
    int                      b;
    int                      j;
    logic signed [49:0]      prod;
    logic signed [33:0]      total;
    logic signed [33:0]      bumped;
    logic signed [VAL_W-1:0] thr;
    bin_result_t             res;
    if (upsample_q == 0)
      nbins = 1;
    else if (upsample_q > ATSG_MAX_UPSAMPLE)
      nbins = ATSG_MAX_UPSAMPLE;
    else
      nbins = int'(upsample_q);
    for (b = 0; b < nbins; b++) begin
      // decay each component, rounding to nearest with ties upward
      total = '0;
      for (j = 0; j < ATSG_NUM_COMPONENTS; j++) begin
        prod      = part_q[j] * $signed({1'b0, decay_q[j]}) + 50'sd32768;
        part_q[j] = prod[47:16];
        total     = total + part_q[j];
      end
      thr = clip32(total);
      res.spike = 1'b0;
      if (refr_count_q != 0) begin
        refr_count_q = refr_count_q - 1'b1;
      end else if (volt > thr) begin
        res.spike = 1'b1;
        for (j = 0; j < ATSG_NUM_COMPONENTS; j++) begin
          bumped    = part_q[j];
          bumped    = bumped + jump_q[j];
          part_q[j] = clip32(bumped);
        end
        refr_count_q = refr_bins_q;
      end
      res.thr  = thr;
      res.last = (b == nbins - 1);
      expected_bins.push_back(res);
    end
  endtask

  // Compare one delivered bin against the oldest prediction
  task automatic check_bin();
    bin_result_t want;
    if (expected_bins.size() == 0) begin
      report_mismatch("unrequested result", 32'd0, out_threshold_sum);
      return;
    end
    want = expected_bins.pop_front();
    if (out_spike !== want.spike)
      report_mismatch("spike", want.spike, out_spike);
    if (out_threshold_sum !== want.thr)
      report_mismatch("threshold_sum", want.thr, out_threshold_sum);
    if (out_last_bin !== want.last)
      report_mismatch("last_bin", want.last, out_last_bin);
    bins_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_bins(in_drive_voltage);
      if (out_valid && !out_stall) check_bin();
    end
    bins_pending = expected_bins.size();
  end

endmodule

### dv/tb_adaptive_threshold_spike_generator_top.sv
// ---------------------------------------------------------------------------
// tb_adaptive_threshold_spike_generator_top
// Drives voltage requests and register writes into the spike generator with
// random gaps and output stalls: a directed pass over saturation, rounding,
// refractory and upsample corners, then random register settings and
// voltages. A side checker predicts and compares every fine bin.
// ---------------------------------------------------------------------------
module tb_adaptive_threshold_spike_generator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atsg_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_PAUSE     = 40;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_SAMPLES = 14;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_drive_voltage = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_spike;
  logic signed [VAL_W-1:0] out_threshold_sum;
  logic                    out_last_bin;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_DECAY_FAST;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int   mismatch_count;
  int   bins_pending;
  int   cycle_count = 0;
  int   stall_run = 0;
  int   stall_roll;
  bit   calm = 1'b0;
  bit   holding = 1'b0;
  event hold_go;
  logic [VAL_W-1:0] volt_seq[$];

  adaptive_threshold_spike_generator_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_drive_voltage  (in_drive_voltage),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_spike         (out_spike),
    .out_threshold_sum (out_threshold_sum),
    .out_last_bin      (out_last_bin),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  atsg_bin_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_drive_voltage  (in_drive_voltage),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_spike         (out_spike),
    .out_threshold_sum (out_threshold_sum),
    .out_last_bin      (out_last_bin),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .bins_pending      (bins_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold the result channel off for a long stretch on request
  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      holding = 1'b0;
    end
  end

  // Stall the result channel: mostly short bursts, a few long ones
  always @(negedge clk) begin
    if (holding) begin
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 65) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 93) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(2, 0);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(40, 10);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [VAL_W-1:0] pick_voltage();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return $urandom;
    if (roll < 28) return roll[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    // mostly -2.0 .. 6.0 in Q16.16, near typical thresholds
    return 32'($urandom_range(32'h8_0000)) - 32'h2_0000;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_decay();
    logic [CFG_DATA_W-1:0] data;
    int                    roll;
    data = $urandom;
    roll = $urandom_range(99);
    if (roll < 10)      data[DECAY_W-1:0] = '0;
    else if (roll < 20) data[DECAY_W-1:0] = '1;
    else                data[DECAY_W-1:0] = 16'($urandom_range(65535, 50000));
    return data;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_jump();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 32'($urandom_range(32'h4_0000));
    if (roll < 85) return -32'($urandom_range(32'h1_0000));
    return $urandom;
  endfunction

  // Offer one voltage request and hold it until accepted
  task automatic send_voltage(input logic [VAL_W-1:0] volt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_drive_voltage <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_drive_voltage <= volt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_seq();
    foreach (volt_seq[i]) send_voltage(volt_seq[i]);
  endtask

  // Drop the request valid and wait for every predicted bin
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (bins_pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all registers with random values, junk in unused upper bits
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] data;
    int                    roll;
    write_reg(REG_DECAY_FAST, pick_decay());
    write_reg(REG_DECAY_SLOW, pick_decay());
    write_reg(REG_JUMP_FAST, pick_jump());
    write_reg(REG_JUMP_SLOW, pick_jump());
    data = $urandom;
    data[REFR_W-1:0] = ($urandom_range(99) < 80) ? 16'($urandom_range(6))
                                                 : 16'($urandom_range(40));
    write_reg(REG_REFRACTORY_BINS, data);
    data = $urandom;
    roll = $urandom_range(99);
    if (roll < 5)       data[UPS_W-1:0] = '0;
    else if (roll < 10) data[UPS_W-1:0] = 5'($urandom_range(31, 17));
    else if (roll < 70) data[UPS_W-1:0] = 5'($urandom_range(6, 1));
    else                data[UPS_W-1:0] = 5'($urandom_range(16, 1));
    write_reg(REG_UPSAMPLE_FACTOR, data);
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED_HI, $urandom);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Power-up settings: first bin blocked, zero threshold, strict compare
    volt_seq = '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'h8000_0000};
    send_seq();
    drain();

    // Maximum jumps with full and no decay: saturate sum and components
    write_reg(REG_DECAY_FAST, 32'h0000_0000);
    write_reg(REG_DECAY_SLOW, 32'hFFFF_FFFF);
    write_reg(REG_JUMP_FAST, 32'h7FFF_FFFF);
    write_reg(REG_JUMP_SLOW, 32'h7FFF_FFFF);
    write_reg(REG_REFRACTORY_BINS, 32'h0000_0000);
    write_reg(REG_UPSAMPLE_FACTOR, 32'h0000_0010);
    volt_seq = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
    send_seq();
    drain();

    // Minimum jumps, upsample zero, ignored register indexes
    write_reg(REG_DECAY_FAST, 32'h0000_FFFF);
    write_reg(REG_DECAY_SLOW, 32'hFFFF_0000);
    write_reg(REG_JUMP_FAST, 32'h8000_0000);
    write_reg(REG_JUMP_SLOW, 32'h0000_0001);
    write_reg(REG_REFRACTORY_BINS, 32'h0000_0003);
    write_reg(REG_UPSAMPLE_FACTOR, 32'hFFFF_FFE0);
    write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_HI, 32'h0000_0000);
    volt_seq = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h0000_0000, 32'h0000_0001};
    send_seq();
    drain();

    // Typical neuron: small jumps, short refractory period
    write_reg(REG_DECAY_FAST, 32'd60000);
    write_reg(REG_DECAY_SLOW, 32'd65000);
    write_reg(REG_JUMP_FAST, 32'h0002_0000);
    write_reg(REG_JUMP_SLOW, 32'h0000_8000);
    write_reg(REG_REFRACTORY_BINS, 32'h0000_0002);
    write_reg(REG_UPSAMPLE_FACTOR, 32'h0000_0005);
    volt_seq = '{32'h0001_0000, 32'h0003_0000, 32'h0000_8000, 32'h0005_0000,
                 32'h7FFF_FFFF};
    send_seq();
    drain();

    // Random settings and voltages; one phase fills the block under a
    // long output hold, another runs with no idling at all
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      random_settings();
      if (phase == 2) begin
        write_reg(REG_UPSAMPLE_FACTOR, 32'h0000_0010);
        calm = 1'b1;
        -> hold_go;
      end
      if (phase == 4) calm = 1'b1;
      repeat (PHASE_SAMPLES) send_voltage(pick_voltage());
      drain();
      calm = 1'b0;
    end

    // Longest refractory period and an out-of-range upsample factor
    write_reg(REG_JUMP_FAST, 32'h0001_0000);
    write_reg(REG_JUMP_SLOW, 32'h0000_0000);
    write_reg(REG_REFRACTORY_BINS, 32'h0000_FFFF);
    write_reg(REG_UPSAMPLE_FACTOR, 32'h0000_001F);
    volt_seq = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000};
    send_seq();
    drain();

    repeat (END_PAUSE) @(posedge clk);
    if (mismatch_count == 0 && bins_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/atsg_pkg.sv
sv/atsg_cfg_regs.sv
sv/atsg_datapath.sv
sv/atsg_ctrl.sv
sv/adaptive_threshold_spike_generator_top.sv
sv/atsg_checker.sv
dv/atsg_bin_checker.sv
dv/tb_adaptive_threshold_spike_generator_top.sv
